// ===== sv/afsrp_pkg.sv =====
// Package for the API frame scan-report parser: framing constants, capture
// offsets and the structs passed between the parser core and its capture unit.
// No dependencies.
`default_nettype none

package afsrp_pkg;

   localparam int unsigned IDX_W    = 16;
   localparam int unsigned BYTE_W   = 8;

   localparam logic [BYTE_W-1:0] START_BYTE  = 8'h7E;
   localparam logic [BYTE_W-1:0] TYPE_AT_RSP = 8'h88;
   localparam logic [BYTE_W-1:0] CMD_FIRST   = 8'h41;
   localparam logic [BYTE_W-1:0] CMD_SECOND  = 8'h53;

   // Frame offsets: header positions and the bytes that are captured.
   localparam logic [IDX_W-1:0] OFS_HUNT    = 16'd0;
   localparam logic [IDX_W-1:0] OFS_LEN_HI  = 16'd1;
   localparam logic [IDX_W-1:0] OFS_LEN_LO  = 16'd2;
   localparam logic [IDX_W-1:0] OFS_TYPE    = 16'd3;
   localparam logic [IDX_W-1:0] OFS_CMD0    = 16'd5;
   localparam logic [IDX_W-1:0] OFS_CMD1    = 16'd6;
   localparam logic [IDX_W-1:0] OFS_CHANNEL = 16'd9;
   localparam logic [IDX_W-1:0] OFS_PAN_HI  = 16'd10;
   localparam logic [IDX_W-1:0] OFS_PAN_LO  = 16'd11;
   localparam logic [IDX_W-1:0] OFS_LQI     = 16'd22;
   localparam logic [IDX_W-1:0] OFS_RSSI    = 16'd23;

   // Bytes after the length field up to the checksum: type/data plus checksum.
   localparam logic [IDX_W:0]   END_BIAS    = 17'd3;
   localparam logic [IDX_W-1:0] END_MAX     = 16'hFFFF;

   typedef struct packed {
      logic [BYTE_W-1:0] signal_strength;
      logic [BYTE_W-1:0] link_quality;
      logic [BYTE_W-1:0] channel;
      logic [15:0]       pan_id;
   } afsrp_report_type;

   typedef struct packed {
      logic              match;
      afsrp_report_type  report;
   } afsrp_capture_type;

endpackage

`default_nettype wire

// ===== sv/api_frame_scan_report_parser_core.sv =====
// Top level of the API frame scan-report parser: offset counter, frame end
// computation and the result register. Depends on afsrp_pkg and afsrp_capture.
//
//   Channel   Direction  tdata fields (lowest bit up)                       Width
//   req_      in         rx_byte[7:0]                                       8
//   rsp_      out        pan_id[15:0] channel[7:0] link_quality[7:0]        40
//                        signal_strength[7:0]
//
// Every accepted request is processed in the cycle in which it is accepted:
// the offset counter, the capture registers and, at the last byte of a
// matching frame, the result register are all loaded at that clock edge.
// A result therefore appears in the cycle after the byte that ends its frame,
// and one request can be accepted in every cycle while the result side is not stalling.
// The result register is a single stage: requests are refused only while a
// result is held and the result side is stalling; req_tready is then low.
// Reset is synchronous and clears the counter, the captured bytes and the
// result valid flag.
`default_nettype none

module api_frame_scan_report_parser_core
   import afsrp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [39:0] rsp_tdata    // [15:0] pan_id, [23:16] channel,
                                         // [31:24] link_quality,
                                         // [39:32] signal_strength
);

   // Offset of the next byte in the frame; zero means hunting for the start.
   logic [IDX_W-1:0]  idx_ff, idx_in;
   // Offset of the last byte of the frame (the checksum).
   logic [IDX_W-1:0]  end_ff, end_in;
   logic [BYTE_W-1:0] len_hi_ff, len_hi_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   afsrp_report_type       rsp_data_ff, rsp_data_in;

   logic                   accept;
   logic                   in_body;
   logic                   frame_done;
   logic [IDX_W:0]         end_sum;
   afsrp_capture_type      cap_next;

   // The result register may be refilled in the cycle in which it drains.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   // Offsets from three onwards are the frame body, including the checksum.
   assign in_body    = (idx_ff >= OFS_TYPE);
   assign frame_done = accept && in_body && (idx_ff == end_ff);

   // Length plus three, saturated so that the counter never wraps.
   assign end_sum = {1'b0, len_hi_ff, req_tdata} + END_BIAS;

   afsrp_capture u_capture (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (accept && in_body),
      .wr_index (idx_ff),
      .wr_byte  (req_tdata),
      .cap_next (cap_next)
   );

   always_comb begin
      idx_in    = idx_ff;
      end_in    = end_ff;
      len_hi_in = len_hi_ff;
      if (accept) begin
         unique case (idx_ff)
            OFS_HUNT: begin
               if (req_tdata == START_BYTE) begin
                  idx_in = OFS_LEN_HI;
               end
            end
            OFS_LEN_HI: begin
               len_hi_in = req_tdata;
               idx_in    = OFS_LEN_LO;
            end
            OFS_LEN_LO: begin
               end_in = end_sum[IDX_W] ? END_MAX : end_sum[IDX_W-1:0];
               idx_in = OFS_TYPE;
            end
            default: begin
               if (idx_ff == end_ff) begin
                  idx_in = OFS_HUNT;
               end else begin
                  idx_in = idx_ff + 16'd1;
               end
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (frame_done && cap_next.match) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = cap_next.report;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= OFS_HUNT;
         end_ff       <= '0;
         len_hi_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         end_ff       <= end_in;
         len_hi_ff    <= len_hi_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Inside a frame body the counter never passes the last offset.
   assert property (@(posedge clock) disable iff (reset)
      (idx_ff >= OFS_TYPE) |-> (idx_ff <= end_ff) && (end_ff >= OFS_TYPE))
      else $error("frame offset beyond frame end");

   // The last byte of a frame always returns the parser to hunting.
   assert property (@(posedge clock) disable iff (reset)
      frame_done |=> (idx_ff == OFS_HUNT))
      else $error("parser did not return to hunting after frame end");

   // Header bytes never produce a result.
   assert property (@(posedge clock) disable iff (reset)
      (accept && !in_body) |=> (rsp_valid_ff == $past(rsp_valid_ff && !rsp_tready)))
      else $error("result produced outside a frame end");

   // A request is never accepted while a held result is stalled.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !accept)
      else $error("request accepted while result register is blocked");

endmodule

`default_nettype wire

// ===== sv/afsrp_capture.sv =====
// Capture registers of the scan-report parser and the frame-type/command match.
// Depends on afsrp_pkg.
`default_nettype none

module afsrp_capture
   import afsrp_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              wr_en,
   input  wire logic [IDX_W-1:0]  wr_index,
   input  wire logic [BYTE_W-1:0] wr_byte,
   output      afsrp_capture_type cap_next
);

   logic [BYTE_W-1:0] type_ff, type_in;
   logic [BYTE_W-1:0] cmd0_ff, cmd0_in;
   logic [BYTE_W-1:0] cmd1_ff, cmd1_in;
   logic [BYTE_W-1:0] chan_ff, chan_in;
   logic [BYTE_W-1:0] panhi_ff, panhi_in;
   logic [BYTE_W-1:0] panlo_ff, panlo_in;
   logic [BYTE_W-1:0] lqi_ff, lqi_in;
   logic [BYTE_W-1:0] rssi_ff, rssi_in;

   // Next values are also the view used by the end-of-frame check, so a
   // capture on the last byte is seen by that check.
   always_comb begin
      type_in  = type_ff;
      cmd0_in  = cmd0_ff;
      cmd1_in  = cmd1_ff;
      chan_in  = chan_ff;
      panhi_in = panhi_ff;
      panlo_in = panlo_ff;
      lqi_in   = lqi_ff;
      rssi_in  = rssi_ff;
      if (wr_en) begin
         unique case (wr_index)
            OFS_TYPE:    type_in  = wr_byte;
            OFS_CMD0:    cmd0_in  = wr_byte;
            OFS_CMD1:    cmd1_in  = wr_byte;
            OFS_CHANNEL: chan_in  = wr_byte;
            OFS_PAN_HI:  panhi_in = wr_byte;
            OFS_PAN_LO:  panlo_in = wr_byte;
            OFS_LQI:     lqi_in   = wr_byte;
            OFS_RSSI:    rssi_in  = wr_byte;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         type_ff  <= '0;
         cmd0_ff  <= '0;
         cmd1_ff  <= '0;
         chan_ff  <= '0;
         panhi_ff <= '0;
         panlo_ff <= '0;
         lqi_ff   <= '0;
         rssi_ff  <= '0;
      end else begin
         type_ff  <= type_in;
         cmd0_ff  <= cmd0_in;
         cmd1_ff  <= cmd1_in;
         chan_ff  <= chan_in;
         panhi_ff <= panhi_in;
         panlo_ff <= panlo_in;
         lqi_ff   <= lqi_in;
         rssi_ff  <= rssi_in;
      end
   end

   assign cap_next.match = (type_in == TYPE_AT_RSP) && (cmd0_in == CMD_FIRST)
                           && (cmd1_in == CMD_SECOND);
   assign cap_next.report.pan_id          = {panhi_in, panlo_in};
   assign cap_next.report.channel         = chan_in;
   assign cap_next.report.link_quality    = lqi_in;
   assign cap_next.report.signal_strength = rssi_in;

endmodule

`default_nettype wire
